@@ src/circular_range_wrap_diff_limit_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef CIRCULAR_RANGE_WRAP_DIFF_LIMIT_CORE_MACROS_SVH
`define CIRCULAR_RANGE_WRAP_DIFF_LIMIT_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CRW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ src/crwd_pkg.sv @@
// Shared types, constants and functions of the circular wrap core.
package crwd_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DW = 32;
    localparam int RW = 36;
    localparam logic [DW-1:0] UPPER_RESET = DW'(360) << FRAC_BITS;

    localparam logic [1:0] REG_LOWER = 2'd0;
    localparam logic [1:0] REG_UPPER = 2'd1;
    localparam logic [1:0] REG_LMIN  = 2'd2;
    localparam logic [1:0] REG_LMAX  = 2'd3;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_MIN    = 2'd1;
    localparam logic [1:0] ST_MAX    = 2'd2;

    // quotient bits computed by each divider stage
    localparam int QBITS = 4;
    localparam int NSTG  = (RW + QBITS - 1) / QBITS;

    typedef logic signed [RW-1:0] wide_t;

    // one value being wrapped through the divider
    typedef struct packed {
        logic  neg;      // dividend was negative
        logic  pass;     // inside range or zero width
        wide_t base;     // hi or lo, or the value itself on pass
        logic [RW-1:0] rem;  // running remainder magnitude
        logic [RW-1:0] num;  // remaining dividend bits
    } wrap_t;

    // front-end word queued toward the back end
    typedef struct packed {
        wide_t lo;
        wide_t hi;
        wide_t v;
        wide_t t;
        wide_t mn;
        wide_t mx;
    } item_t;

    function automatic wide_t mag(input wide_t x);
        mag = x[RW-1] ? -x : x;
    endfunction

    // shortest signed path from v to t on a circle of width r
    function automatic wide_t shortest(input wide_t v, input wide_t t, input wide_t r);
        wide_t d, up, dn;
        d  = t - v;
        up = d - r;
        dn = d + r;
        if (mag(up) < mag(dn) && mag(up) < mag(d)) shortest = up;
        else if (mag(dn) < mag(up) && mag(dn) < mag(d)) shortest = dn;
        else shortest = d;
    endfunction
endpackage

@@ src/circular_range_wrap_diff_limit_core.sv @@
// Circular range wrap, shortest difference and arc clamp: one word per cycle while the
// output is not stalled; the path runs through 9 remainder stages of 4 quotient bits each,
// a two-entry queue and the output register.
// Bounds are reordered if reversed; equal bounds pass values through.
module circular_range_wrap_diff_limit_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // raw_value, other_value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // wrapped_value, shortest_difference, limited_value, limit_status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import crwd_pkg::*;

    logic [DW-1:0] lower_reg, upper_reg, lmin_reg, lmax_reg;
    logic          f_valid, f_ready, q_valid, q_ready;
    item_t         f_item, q_item;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= '0;
            upper_reg <= UPPER_RESET;
            lmin_reg  <= '0;
            lmax_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LOWER: lower_reg <= cfg_data;
                REG_UPPER: upper_reg <= cfg_data;
                REG_LMIN:  lmin_reg  <= cfg_data;
                REG_LMAX:  lmax_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    crwd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .cfg_regs({lmax_reg, lmin_reg, upper_reg, lower_reg}),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    crwd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    crwd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

@@ src/crwd_front.sv @@
// Front end: orders the bounds and wraps four values with a pipelined remainder.
module crwd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          in_data,
    input  logic [4*32-1:0]      cfg_regs,
    output logic                 out_valid,
    input  logic                 out_ready,
    output crwd_pkg::item_t      out_item
);
    import crwd_pkg::*;

    logic              vld_reg [NSTG+1];
    wrap_t             w_reg   [NSTG+1][4];
    wide_t             lo_reg  [NSTG+1];
    wide_t             hi_reg  [NSTG+1];
    logic              adv;
    wide_t             a, b, lo_c, hi_c, r_c;
    wide_t             src [4];
    wrap_t             w0  [4];
    wrap_t             ws  [NSTG][4];

    // pipeline advances when its last stage is empty or taken
    assign adv = !vld_reg[NSTG] || out_ready;
    assign in_ready = adv;

    // order the bounds and set up each value
    always_comb begin
        a = RW'($signed(cfg_regs[31:0]));
        b = RW'($signed(cfg_regs[63:32]));
        lo_c = (a > b) ? b : a;
        hi_c = (a > b) ? a : b;
        r_c  = hi_c - lo_c;
        src[0] = RW'($signed(in_data[31:0]));
        src[1] = RW'($signed(in_data[63:32]));
        src[2] = RW'($signed(cfg_regs[95:64]));
        src[3] = RW'($signed(cfg_regs[127:96]));
        for (int k = 0; k < 4; k++) begin
            wide_t diff;
            diff = (src[k] < lo_c) ? src[k] - lo_c : src[k] - hi_c;
            w0[k].pass = (r_c == '0) || (src[k] >= lo_c && src[k] <= hi_c);
            w0[k].neg  = diff[RW-1];
            w0[k].base = w0[k].pass ? src[k] : ((src[k] < lo_c) ? hi_c : lo_c);
            w0[k].rem  = '0;
            w0[k].num  = diff[RW-1] ? RW'(-diff) : RW'(diff);
        end
    end

    // one restoring-division step set per stage, QBITS quotient bits each
    always_comb begin
        for (int s = 0; s < NSTG; s++) begin
            for (int k = 0; k < 4; k++) begin
                logic [RW:0]   rr;
                logic [RW-1:0] rm, nm, rv;
                rv = RW'(hi_reg[s] - lo_reg[s]);
                rm = w_reg[s][k].rem;
                nm = w_reg[s][k].num;
                for (int q = 0; q < QBITS; q++) begin
                    rr = {rm, nm[RW-1]};
                    nm = {nm[RW-2:0], 1'b0};
                    if (rv != '0 && rr >= {1'b0, rv}) rr = rr - {1'b0, rv};
                    rm = rr[RW-1:0];
                end
                ws[s][k] = w_reg[s][k];
                ws[s][k].rem = rm;
                ws[s][k].num = nm;
            end
        end
    end

    // advance the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NSTG; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 0; s < NSTG; s++) vld_reg[s+1] <= vld_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg[0] <= lo_c;
            hi_reg[0] <= hi_c;
            for (int k = 0; k < 4; k++) w_reg[0][k] <= w0[k];
            for (int s = 0; s < NSTG; s++) begin
                lo_reg[s+1] <= lo_reg[s];
                hi_reg[s+1] <= hi_reg[s];
                for (int k = 0; k < 4; k++) w_reg[s+1][k] <= ws[s][k];
            end
        end
    end

    // form the wrapped results
    function automatic wide_t fin(input wrap_t w);
        wide_t rm;
        rm = wide_t'(w.rem);
        fin = w.pass ? w.base : (w.neg ? w.base - rm : w.base + rm);
    endfunction

    assign out_valid   = vld_reg[NSTG];
    assign out_item.lo = lo_reg[NSTG];
    assign out_item.hi = hi_reg[NSTG];
    assign out_item.v  = fin(w_reg[NSTG][0]);
    assign out_item.t  = fin(w_reg[NSTG][1]);
    assign out_item.mn = fin(w_reg[NSTG][2]);
    assign out_item.mx = fin(w_reg[NSTG][3]);
endmodule

@@ src/crwd_queue.sv @@
// Two-entry queue between front and back ends.
module crwd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  crwd_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output crwd_pkg::item_t out_item
);
    import crwd_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // track pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // store the word
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_item;
    end
endmodule

@@ src/crwd_back.sv @@
// Back end: shortest difference, arc clamp and output register.
module crwd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  crwd_pkg::item_t in_item,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [103:0]    m_tdata
);
    import crwd_pkg::*;

    logic         vld_reg;
    logic [103:0] data_reg;
    wide_t        r, diff, dmin, dmax, lim;
    logic [DW-1:0] diff_sat;
    logic [1:0]   status;
    logic         outside;

    assign in_ready = !vld_reg || m_tready;

    // compute the result word
    always_comb begin
        r    = in_item.hi - in_item.lo;
        diff = shortest(in_item.v, in_item.t, r);
        if (diff > wide_t'(32'sh7fffffff))       diff_sat = 32'h7fffffff;
        else if (diff < -wide_t'(33'sh80000000)) diff_sat = 32'h80000000;
        else diff_sat = diff[DW-1:0];
        dmin = mag(shortest(in_item.v, in_item.mn, r));
        dmax = mag(shortest(in_item.v, in_item.mx, r));
        outside = (in_item.mn < in_item.mx && (in_item.v > in_item.mx || in_item.v < in_item.mn))
               || (in_item.mn > in_item.mx && in_item.v > in_item.mx && in_item.v < in_item.mn);
        lim = in_item.v;
        status = ST_INSIDE;
        if (in_item.mn != in_item.mx && outside) begin
            if (dmin < dmax) begin
                lim = in_item.mn;
                status = ST_MIN;
            end else begin
                lim = in_item.mx;
                status = ST_MAX;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= 1'b0;
        else if (in_ready) vld_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid)
            data_reg <= {6'd0, status, lim[DW-1:0], diff_sat, in_item.v[DW-1:0]};
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
endmodule

@@ src/crwd_checker.sv @@
// Port checker for the core, bound to the top level.
`include "circular_range_wrap_diff_limit_core_macros.svh"
module crwd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);
    `CRW_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CRW_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `CRW_ASSERT_IMPL(a_status_code, aclk, aresetn, m_tvalid, m_tdata[97:96] != 2'd3)
    `CRW_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[103:98] == 6'd0)
endmodule

bind circular_range_wrap_diff_limit_core crwd_checker u_crwd_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
